FILE: design/grouped_undo_redo_stack_defines.svh
// ----------------------------------------------------------------------------
// grouped undo/redo stack assertion macros
// shared assertion forms, clocked on clk_i and held off during reset
// ----------------------------------------------------------------------------
`ifndef GROUPED_UNDO_REDO_STACK_DEFINES_SVH
`define GROUPED_UNDO_REDO_STACK_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define GURS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define GURS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/gurs_pkg.sv
// ----------------------------------------------------------------------------
// gurs_pkg
// sizes, codes and the result beat type of the grouped undo/redo stack
// ----------------------------------------------------------------------------
package gurs_pkg;

  localparam int HistDepth = 64;
  localparam int WordWidth = 32;

  // fixed port field widths
  localparam int CmdW   = 32;
  localparam int OpW    = 3;
  localparam int LevelW = 7;

  // stored word is masked to the smaller of the history and port widths
  localparam int StoreW = (WordWidth < CmdW) ? WordWidth : CmdW;
  localparam int IdxW   = $clog2(HistDepth);
  localparam int LvlW   = $clog2(HistDepth + 1);
  localparam int EntryW = StoreW + 1;

  typedef enum logic [OpW-1:0] {
    OP_PUSH         = 3'd0,
    OP_UNDO         = 3'd1,
    OP_REDO         = 3'd2,
    OP_STROKE_BEGIN = 3'd3,
    OP_STROKE_END   = 3'd4,
    OP_CLEAR        = 3'd5
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ACK   = 2'd3
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [CmdW-1:0]     replay_word;
    logic                apply_inverse;
    logic                word_valid;
    logic                last_of_run;
    logic [LevelW-1:0]   applied_level;
    logic [LevelW-1:0]   stored_level;
  } res_t;

endpackage

FILE: design/gurs_if.sv
// ----------------------------------------------------------------------------
// gurs_if
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
interface gurs_cmd_if;
  import gurs_pkg::*;

  logic            valid;
  logic            ready;
  logic [OpW-1:0]  opcode;
  logic [CmdW-1:0] command_word;

  modport source (output valid, output opcode, output command_word, input ready);
  modport sink   (input valid, input opcode, input command_word, output ready);
endinterface

interface gurs_res_if;
  import gurs_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [CmdW-1:0]   replay_word;
  logic              apply_inverse;
  logic              word_valid;
  logic              last_of_run;
  logic [LevelW-1:0] applied_level;
  logic [LevelW-1:0] stored_level;

  modport source (
    output valid, output status, output replay_word, output apply_inverse,
    output word_valid, output last_of_run, output applied_level,
    output stored_level, input ready
  );
  modport sink (
    input valid, input status, input replay_word, input apply_inverse,
    input word_valid, input last_of_run, input applied_level,
    input stored_level, output ready
  );
endinterface

FILE: design/grouped_undo_redo_stack.sv
// ----------------------------------------------------------------------------
// grouped_undo_redo_stack
// bounded command history with grouped undo and redo replay
// ----------------------------------------------------------------------------
//  channel   dir  beat
//  cmd_i     in   opcode, command_word
//  res_o     out  status, replay_word, apply_inverse, word_valid,
//                 last_of_run, applied_level, stored_level
//
//  push, stroke, clear and empty undo/redo: one result beat per command beat
//  undo: a ram read, then one word per cycle while res_o takes beats
//  redo: a lead-in (word read plus lookahead of the next mark), then one word
//    per cycle while res_o takes beats; the single-port history ram sets the lead-in
//  async active-low reset clears levels and stroke flags; ram is not cleared
//  a stalled res_o holds the output register and pauses the walk in place
// ----------------------------------------------------------------------------
module grouped_undo_redo_stack (
  input  logic       clk_i,
  input  logic       rst_ni,
  gurs_cmd_if.sink   cmd_i,
  gurs_res_if.source res_o
);
  import gurs_pkg::*;

  // sequencer to output register
  logic res_valid;
  logic res_ready;
  res_t res;

  // output register, one result beat deep
  logic out_valid_q;
  res_t out_q;

  gurs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .in_opcode_i(cmd_i.opcode),
    .in_word_i  (cmd_i.command_word),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // take a new beat when the register is empty or being drained
  assign res_ready = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.status        = out_q.status;
  assign res_o.replay_word   = out_q.replay_word;
  assign res_o.apply_inverse = out_q.apply_inverse;
  assign res_o.word_valid    = out_q.word_valid;
  assign res_o.last_of_run   = out_q.last_of_run;
  assign res_o.applied_level = out_q.applied_level;
  assign res_o.stored_level  = out_q.stored_level;

endmodule

FILE: design/gurs_ram.sv
// ----------------------------------------------------------------------------
// gurs_ram
// single-port synchronous ram, read data registered on a read enable
// ----------------------------------------------------------------------------
module gurs_ram #(
  parameter int Depth = 64,
  parameter int Width = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/gurs_seq.sv
// ----------------------------------------------------------------------------
// gurs_seq
// history sequencer: level counters, stroke flags and the walk over the ram
// ----------------------------------------------------------------------------
module gurs_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [gurs_pkg::OpW-1:0]         in_opcode_i,
  input  logic [gurs_pkg::CmdW-1:0]        in_word_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output gurs_pkg::res_t                   res_o
);
  import gurs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_UEMIT,
    S_RFETCH,
    S_RPEEK,
    S_RTAIL
  } state_e;

  state_e            state_q, state_d;
  logic [LvlW-1:0]   stored_q, stored_d;
  logic [LvlW-1:0]   applied_q, applied_d;
  logic              stroke_q, stroke_d;
  logic              opened_q, opened_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [StoreW-1:0] word_q, word_d;
  res_t              res_q, res_d;

  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_addr;
  logic [EntryW-1:0] mem_wdata, mem_rdata;
  logic              rd_mark;
  logic [StoreW-1:0] rd_word;

  gurs_ram #(
    .Depth(HistDepth),
    .Width(EntryW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign rd_mark = mem_rdata[StoreW];
  assign rd_word = mem_rdata[StoreW-1:0];

  always_comb begin
    logic [LvlW-1:0] applied_inc;
    logic [LvlW-1:0] idx_inc;
    logic            opens;
    res_t            r;

    state_d   = state_q;
    stored_d  = stored_q;
    applied_d = applied_q;
    stroke_d  = stroke_q;
    opened_d  = opened_q;
    idx_d     = idx_q;
    word_d    = word_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = idx_q;
    mem_wdata = '0;
    res_valid_o = 1'b0;
    in_ready_o  = 1'b0;

    applied_inc = applied_q + LvlW'(1);
    idx_inc     = LvlW'(idx_q) + LvlW'(1);
    opens       = !stroke_q || !opened_q;

    r.status        = ST_ACK;
    r.replay_word   = '0;
    r.apply_inverse = 1'b0;
    r.word_valid    = 1'b0;
    r.last_of_run   = 1'b1;
    r.applied_level = LevelW'(applied_q);
    r.stored_level  = LevelW'(stored_q);

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_RESP;
          unique case (in_opcode_i)
            OP_PUSH: begin
              if (applied_q >= LvlW'(HistDepth)) begin
                r.status = ST_FULL;
              end else begin
                // redo tail dropped: the new entry lands at the applied level
                mem_we    = 1'b1;
                mem_addr  = IdxW'(applied_q);
                mem_wdata = {opens, in_word_i[StoreW-1:0]};
                stored_d  = applied_inc;
                applied_d = applied_inc;
                if (stroke_q) begin
                  opened_d = 1'b1;
                end
                r.status        = ST_DONE;
                r.applied_level = LevelW'(applied_inc);
                r.stored_level  = LevelW'(applied_inc);
              end
            end
            OP_UNDO: begin
              if (applied_q == '0) begin
                r.status = ST_EMPTY;
              end else begin
                mem_re   = 1'b1;
                mem_addr = IdxW'(applied_q - LvlW'(1));
                idx_d    = IdxW'(applied_q - LvlW'(1));
                state_d  = S_UEMIT;
              end
            end
            OP_REDO: begin
              if (applied_q >= stored_q) begin
                r.status = ST_EMPTY;
              end else begin
                mem_re   = 1'b1;
                mem_addr = IdxW'(applied_q);
                idx_d    = IdxW'(applied_q);
                state_d  = S_RFETCH;
              end
            end
            OP_STROKE_BEGIN: begin
              stroke_d = 1'b1;
              opened_d = 1'b0;
            end
            OP_STROKE_END: begin
              stroke_d = 1'b0;
              opened_d = 1'b0;
            end
            OP_CLEAR: begin
              stored_d        = '0;
              applied_d       = '0;
              opened_d        = 1'b0;
              r.applied_level = '0;
              r.stored_level  = '0;
            end
            default: begin
            end
          endcase
          res_d = r;
        end
      end

      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      // rd data is entry idx_q; it stays put until the next read enable
      S_UEMIT: begin
        r.status        = ST_DONE;
        r.replay_word   = CmdW'(rd_word);
        r.apply_inverse = 1'b1;
        r.word_valid    = 1'b1;
        r.last_of_run   = (idx_q == '0) || rd_mark;
        r.applied_level = LevelW'(idx_q);
        res_valid_o     = 1'b1;
        if (res_ready_i) begin
          applied_d = LvlW'(idx_q);
          if (r.last_of_run) begin
            state_d = S_IDLE;
          end else begin
            mem_re   = 1'b1;
            mem_addr = idx_q - IdxW'(1);
            idx_d    = idx_q - IdxW'(1);
          end
        end
      end

      // first redo word arrives; if more entries are stored, peek at the next for its group mark
      S_RFETCH: begin
        word_d = rd_word;
        if (applied_inc >= stored_q) begin
          state_d = S_RTAIL;
        end else begin
          mem_re   = 1'b1;
          mem_addr = IdxW'(applied_inc);
          idx_d    = IdxW'(applied_inc);
          state_d  = S_RPEEK;
        end
      end

      // word_q is entry idx_q-1, rd data is entry idx_q
      S_RPEEK: begin
        r.status        = ST_DONE;
        r.replay_word   = CmdW'(word_q);
        r.word_valid    = 1'b1;
        r.last_of_run   = rd_mark;
        r.applied_level = LevelW'(applied_inc);
        res_valid_o     = 1'b1;
        if (res_ready_i) begin
          applied_d = applied_inc;
          if (rd_mark) begin
            state_d = S_IDLE;
          end else begin
            word_d = rd_word;
            if (idx_inc >= stored_q) begin
              state_d = S_RTAIL;
            end else begin
              mem_re   = 1'b1;
              mem_addr = IdxW'(idx_inc);
              idx_d    = IdxW'(idx_inc);
            end
          end
        end
      end

      S_RTAIL: begin
        r.status        = ST_DONE;
        r.replay_word   = CmdW'(word_q);
        r.word_valid    = 1'b1;
        r.applied_level = LevelW'(applied_inc);
        res_valid_o     = 1'b1;
        if (res_ready_i) begin
          applied_d = applied_inc;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_o = (state_q == S_RESP) ? res_q : r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      stored_q  <= '0;
      applied_q <= '0;
      stroke_q  <= 1'b0;
      opened_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      stored_q  <= stored_d;
      applied_q <= applied_d;
      stroke_q  <= stroke_d;
      opened_q  <= opened_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    word_q <= word_d;
    res_q  <= res_d;
  end

endmodule

FILE: design/gurs_checker.sv
// ----------------------------------------------------------------------------
// gurs_checker
// port-level checks on the grouped undo/redo stack, bound to the top level
// ----------------------------------------------------------------------------
`include "grouped_undo_redo_stack_defines.svh"

module gurs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cmd_valid_i,
  input logic                          cmd_ready_i,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [1:0]                    status_i,
  input logic [gurs_pkg::CmdW-1:0]     replay_word_i,
  input logic                          word_valid_i,
  input logic                          last_of_run_i,
  input logic [gurs_pkg::LevelW-1:0]   applied_level_i,
  input logic [gurs_pkg::LevelW-1:0]   stored_level_i
);
  import gurs_pkg::*;

  // one command at a time
  `GURS_ASSERT_NEXT(a_one_cmd, cmd_valid_i && cmd_ready_i, !cmd_ready_i, "command taken while busy")

  // no new command while a replay run is still going out
  `GURS_ASSERT_SAME(a_run_busy, res_valid_i && !last_of_run_i, !cmd_ready_i, "command taken mid run")

  `GURS_ASSERT_SAME(a_levels, res_valid_i, applied_level_i <= stored_level_i, "applied above stored")

  `GURS_ASSERT_NEXT(a_hold, res_valid_i && !res_ready_i, res_valid_i && $stable(replay_word_i) && $stable(status_i) && $stable(word_valid_i), "stalled result changed")

endmodule

bind grouped_undo_redo_stack gurs_checker u_gurs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .cmd_valid_i    (cmd_i.valid),
  .cmd_ready_i    (cmd_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .status_i       (res_o.status),
  .replay_word_i  (res_o.replay_word),
  .word_valid_i   (res_o.word_valid),
  .last_of_run_i  (res_o.last_of_run),
  .applied_level_i(res_o.applied_level),
  .stored_level_i (res_o.stored_level)
);
